// ===== rtl/pbr_pkg.sv =====
// ----------------------------------------------------------------------------
// pbr_pkg: shared types and constants of the branch relocator
// Opcode fields, the classified entry that moves from the front end to the
// back end, and the step codes of the six-word far branch.
// ----------------------------------------------------------------------------
package pbr_pkg;

    // primary opcodes
    localparam logic [5:0] OP_BC    = 6'd16;
    localparam logic [5:0] OP_B     = 6'd18;
    localparam logic [5:0] OP_BCCTR = 6'd19;
    localparam logic [5:0] OP_LIS   = 6'd15;
    localparam logic [5:0] OP_ORI   = 6'd24;
    localparam logic [5:0] OP_EXT   = 6'd31;
    localparam logic [5:0] OP_LD    = 6'd58;
    localparam logic [5:0] OP_STD   = 6'd62;

    // extended opcodes and fixed fields
    localparam logic [9:0]  XO_BCCTR  = 10'd528;
    localparam logic [9:0]  XO_MTSPR  = 10'd467;
    // ctr spr number 9 with its two halves swapped
    localparam logic [9:0]  SPR_CTR   = 10'd288;
    localparam logic [4:0]  BO_ALWAYS = 5'd20;
    localparam logic [4:0]  BI_NONE   = 5'd0;
    localparam logic [4:0]  REG_ZERO  = 5'd0;
    localparam logic [4:0]  REG_SP    = 5'd1;
    localparam logic [15:0] SAVE_DISP = 16'hFFD0;

    // step codes of the far branch sequence
    localparam logic [2:0] STEP_STD   = 3'd0;
    localparam logic [2:0] STEP_LIS   = 3'd1;
    localparam logic [2:0] STEP_ORI   = 3'd2;
    localparam logic [2:0] STEP_MTCTR = 3'd3;
    localparam logic [2:0] STEP_LD    = 3'd4;
    localparam logic [2:0] STEP_BCCTR = 3'd5;

    // classified instruction: pass-through word or relocated branch target
    typedef struct packed {
        logic        relocate;
        logic [31:0] data;
        logic [4:0]  bo;
        logic [4:0]  bi;
        logic        lk;
    } pbr_entry_t;

endpackage

// ===== rtl/ppc_branch_relocator.sv =====
// The first result word passes through the front stage register, the queue
//   and the output register before it can transfer.
// A plain word leaves as one output word; a relative branch leaves as six
//   words, one per transfer through the single-word output register.
// The front stage and the queue keep taking input while the back end emits, until the queue is full.
// Reset: synchronous active-low aresetn clears all valid state and sets the
//   scratch register to r0.
// ----------------------------------------------------------------------------
// ppc_branch_relocator: trampoline branch relocation
// Turns a relative b or bc into a six-word branch through ctr and passes
// every other instruction word through unchanged.
// ----------------------------------------------------------------------------
module ppc_branch_relocator
    import pbr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // scratch register write
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] instruction_word, [63:32] instruction_address
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] out_word
    output logic        m_tlast    // last_word
);

    logic [4:0] scratch_reg;
    logic       fq_valid;
    logic       fq_ready;
    pbr_entry_t fq_entry;
    logic       qb_valid;
    logic       qb_pop;
    pbr_entry_t qb_entry;

    // scratch register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scratch_reg <= '0;
        end else if (cfg_we) begin
            scratch_reg <= cfg_wdata;
        end
    end

    // decode and target stage
    pbr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_word  (s_tdata[31:0]),
        .in_addr  (s_tdata[63:32]),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_entry  (fq_entry)
    );

    // decoupling queue
    pbr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_entry  (fq_entry),
        .out_valid (qb_valid),
        .out_pop   (qb_pop),
        .out_entry (qb_entry)
    );

    // word emitter
    pbr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .scratch  (scratch_reg),
        .q_valid  (qb_valid),
        .q_entry  (qb_entry),
        .q_pop    (qb_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_word   (m_tdata),
        .m_last   (m_tlast)
    );

endmodule

// ===== rtl/pbr_front.sv =====
// ----------------------------------------------------------------------------
// pbr_front: decode and target stage
// Classifies each incoming instruction, computes the branch target and
// holds the result in one register stage ahead of the queue.
// ----------------------------------------------------------------------------
module pbr_front
    import pbr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] in_word,
    input  logic [31:0] in_addr,
    output logic        q_valid,
    input  logic        q_ready,
    output pbr_entry_t  q_entry
);

    logic       valid_reg;
    logic       valid_next;
    pbr_entry_t entry_reg;
    pbr_entry_t entry_next;
    logic [5:0]  opcode;
    logic        is_b;
    logic        is_bc;
    logic [31:0] offset;
    logic        take;

    assign s_tready = !valid_reg || q_ready;
    assign take     = s_tvalid && s_tready;

    // decode and target add
    always_comb begin
        opcode = in_word[31:26];
        is_b   = (opcode == OP_B);
        is_bc  = (opcode == OP_BC);
        if (is_b) begin
            offset = {{6{in_word[25]}}, in_word[25:2], 2'b00};
        end else begin
            offset = {{16{in_word[15]}}, in_word[15:2], 2'b00};
        end
        entry_next.relocate = (is_b || is_bc) && !in_word[1];
        entry_next.data     = entry_next.relocate ? (in_addr + offset) : in_word;
        entry_next.bo       = is_b ? BO_ALWAYS : in_word[25:21];
        entry_next.bi       = is_b ? BI_NONE : in_word[20:16];
        entry_next.lk       = in_word[0];
    end

    // stage occupancy
    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (take) begin
            entry_reg <= entry_next;
        end
    end

    assign q_valid = valid_reg;
    assign q_entry = entry_reg;

endmodule

// ===== rtl/pbr_queue.sv =====
// ----------------------------------------------------------------------------
// pbr_queue: decoupling queue
// Small first-in first-out store of classified entries between the front
// end and the back end, head visible without a read delay.
// ----------------------------------------------------------------------------
module pbr_queue
    import pbr_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  pbr_entry_t in_entry,
    output logic       out_valid,
    input  logic       out_pop,
    output pbr_entry_t out_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pbr_entry_t       slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;
    assign out_entry = slots[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

// ===== rtl/pbr_back.sv =====
// ----------------------------------------------------------------------------
// pbr_back: word emitter
// Walks the queue head through the far branch sequence one word per
// transfer, or passes a plain word through, into the output register.
// ----------------------------------------------------------------------------
module pbr_back
    import pbr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [4:0]  scratch,
    input  logic        q_valid,
    input  pbr_entry_t  q_entry,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_word,
    output logic        m_last
);

    logic [2:0]  step_reg;
    logic [2:0]  step_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] word_reg;
    logic        last_reg;
    logic [31:0] word_next;
    logic        last_next;
    logic        load;
    logic        emit;

    assign load  = !out_valid_reg || m_tready;
    assign emit  = load && q_valid;
    assign q_pop = emit && last_next;

    // word for the current step
    always_comb begin
        if (!q_entry.relocate) begin
            word_next = q_entry.data;
            last_next = 1'b1;
        end else begin
            last_next = (step_reg == STEP_BCCTR);
            case (step_reg)
                STEP_STD:   word_next = {OP_STD, scratch, REG_SP, SAVE_DISP};
                STEP_LIS:   word_next = {OP_LIS, scratch, REG_ZERO, q_entry.data[31:16]};
                STEP_ORI:   word_next = {OP_ORI, scratch, scratch, q_entry.data[15:0]};
                STEP_MTCTR: word_next = {OP_EXT, scratch, SPR_CTR, XO_MTSPR, 1'b0};
                STEP_LD:    word_next = {OP_LD, scratch, REG_SP, SAVE_DISP};
                STEP_BCCTR: word_next = {OP_BCCTR, q_entry.bo, q_entry.bi, 5'd0,
                                         XO_BCCTR, q_entry.lk};
                default:    word_next = q_entry.data;
            endcase
        end
    end

    // step counter and output valid
    always_comb begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = q_valid;
        end
        if (emit) begin
            step_next = last_next ? STEP_STD : step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= STEP_STD;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            word_reg <= word_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_word   = word_reg;
    assign m_last   = last_reg;

`ifndef SYNTHESIS
    // step counter stays within the six-word sequence
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= STEP_BCCTR)
        else $error("step counter out of range");

    // a sequence in progress always sits on a relocated head entry
    a_step_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg != STEP_STD) |-> (q_valid && q_entry.relocate))
        else $error("sequence in progress without relocated head");

    // popping the head restarts the sequence
    a_pop_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (step_reg == STEP_STD))
        else $error("step counter not cleared after pop");

    // a relocated entry only pops on its final word
    a_pop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_entry.relocate) |-> (step_reg == STEP_BCCTR))
        else $error("relocated entry popped early");
`endif

endmodule

// ===== tb/sv/tb_ppc_branch_relocator.sv =====
// ----------------------------------------------------------------------------
// tb_ppc_branch_relocator: self-checking bench for the branch relocator
// Sends instruction words with their addresses over the input stream and
// predicts each relocated word in the bench itself. Plain words must come
// back unchanged and relative b/bc must expand to the six-word ctr branch.
// Every output transfer is compared field by field, in order, against the
// predicted words, under random stalls on both streams and in one phase without stalls.
// ----------------------------------------------------------------------------
module tb_ppc_branch_relocator;
    import pbr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 10;

    // one predicted output transfer
    typedef struct packed {
        logic [31:0] out_word;
        logic        last_word;
    } reloc_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;    // [31:0] instruction_word, [63:32] instruction_address
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] out_word
    logic        m_tlast;         // last_word

    reloc_word_t expected_words[$];
    logic [4:0]  scratch_reg = REG_ZERO;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          error_count = 0;
    int          cycle_count = 0;

    ppc_branch_relocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // predict the words emitted for one accepted instruction
    task automatic predict_relocation(input logic [31:0] insn, input logic [31:0] addr);
        logic [5:0]  op;
        logic [31:0] offset;
        logic [31:0] target;
        logic [4:0]  bo;
        logic [4:0]  bi;
        logic [31:0] far_words[6];
        op = insn[31:26];
        if ((op != OP_B && op != OP_BC) || insn[1]) begin
            expected_words.push_back('{out_word: insn, last_word: 1'b1});
            return;
        end
        if (op == OP_B) begin
            offset = {{6{insn[25]}}, insn[25:2], 2'b00};
            bo = BO_ALWAYS;
            bi = BI_NONE;
        end else begin
            offset = {{16{insn[15]}}, insn[15:2], 2'b00};
            bo = insn[25:21];
            bi = insn[20:16];
        end
        target = addr + offset;
        far_words[0] = {OP_STD, scratch_reg, REG_SP, SAVE_DISP};
        far_words[1] = {OP_LIS, scratch_reg, REG_ZERO, target[31:16]};
        far_words[2] = {OP_ORI, scratch_reg, scratch_reg, target[15:0]};
        far_words[3] = {OP_EXT, scratch_reg, SPR_CTR, XO_MTSPR, 1'b0};
        far_words[4] = {OP_LD, scratch_reg, REG_SP, SAVE_DISP};
        far_words[5] = {OP_BCCTR, bo, bi, 5'd0, XO_BCCTR, insn[0]};
        for (int k = 0; k < 6; k++)
            expected_words.push_back('{out_word: far_words[k], last_word: (k == 5)});
    endtask

    // send one instruction and record its predicted words on transfer
    task automatic send_insn(input logic [31:0] insn, input logic [31:0] addr);
        s_tvalid <= 1'b1;
        s_tdata <= {addr, insn};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_relocation(insn, addr);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // stop sending and wait until every predicted word has arrived
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // scratch register write, only while the block is idle
    task automatic write_scratch(input logic [4:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        scratch_reg = value;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly relative branches with random content, the rest noise
    function automatic logic [31:0] random_insn();
        int          kind;
        logic [31:0] insn;
        kind = $urandom_range(99);
        insn = $urandom();
        if (kind < 40)
            insn[31:26] = OP_B;
        else if (kind < 70)
            insn[31:26] = OP_BC;
        else if (kind < 80)
            insn[31:26] = ($urandom_range(1) != 0) ? OP_B : OP_BC;
        if (kind < 70)
            insn[1] = 1'b0;
        else if (kind < 80)
            insn[1] = 1'b1;
        return insn;
    endfunction

    // compare each output transfer with the oldest predicted word
    always @(posedge aclk) begin : result_check
        reloc_word_t exp_word;
        if (m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected transfer: out_word %h last_word %b", m_tdata, m_tlast);
                error_count++;
            end else begin
                exp_word = expected_words.pop_front();
                if (m_tdata !== exp_word.out_word) begin
                    $error("out_word: expected %h, actual %h", exp_word.out_word, m_tdata);
                    error_count++;
                end
                if (m_tlast !== exp_word.last_word) begin
                    $error("last_word: expected %b, actual %b", exp_word.last_word, m_tlast);
                    error_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // plain words, absolute branches and other opcodes go through unchanged
    task automatic test_pass_through();
        send_insn(32'h0000_0000, 32'h0000_0000);
        send_insn(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_insn(32'h4800_0003, 32'h0000_1000);
        send_insn(32'h4000_0002, 32'h8000_0000);
        send_insn(32'h4E80_0420, 32'h0000_2000);
        send_insn(32'h7C08_02A6, 32'h1234_5678);
        wait_idle();
    endtask

    // relative b: offset extremes, link bit, wrap and unaligned address
    task automatic test_relative_b();
        send_insn(32'h4800_0000, 32'h0000_1000);
        send_insn(32'h49FF_FFFC, 32'h1000_0000);
        send_insn(32'h4A00_0000, 32'h0000_0100);
        send_insn(32'h4A00_0001, 32'h0000_0000);
        send_insn(32'h4800_0004, 32'hFFFF_FFFC);
        send_insn(32'h4800_0011, 32'h0000_0003);
        wait_idle();
    endtask

    // relative bc: bo/bi extremes, offset extremes, link bit
    task automatic test_relative_bc();
        send_insn(32'h43FF_7FFC, 32'h0000_8000);
        send_insn(32'h43FF_8000, 32'h1234_5678);
        send_insn(32'h4000_0001, 32'hFFFF_0000);
        send_insn(32'h4182_0010, 32'h0000_2000);
        send_insn(32'h43E0_FFFD, 32'h0000_0000);
        wait_idle();
    endtask

    // highest scratch register, the stack pointer itself, and back to r0
    task automatic test_scratch_extremes();
        write_scratch(5'd31);
        send_insn(32'h4800_0100, 32'h0040_0000);
        send_insn(32'h43FF_8001, 32'h0000_4000);
        wait_idle();
        write_scratch(REG_SP);
        send_insn(32'h4BFF_FFF0, 32'h0000_0010);
        send_insn(32'h4082_0008, 32'hABCD_EF00);
        wait_idle();
        write_scratch(REG_ZERO);
        send_insn(32'h4800_0021, 32'h7FFF_FFF0);
        wait_idle();
    endtask

    // random stream under one stall pattern with a fresh scratch register
    task automatic test_random_phase(input int tx_pct, input int rx_pct, input int n_items);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        write_scratch(5'($urandom_range(31)));
        for (int i = 0; i < n_items; i++)
            send_insn(random_insn(), $urandom());
        wait_idle();
    endtask

    // test sequence
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        tx_idle_pct = 10;
        rx_idle_pct = 30;
        test_pass_through();
        test_relative_b();
        test_relative_bc();
        test_scratch_extremes();
        test_random_phase(29, 81, 85);
        test_random_phase(81, 29, 85);
        test_random_phase(0, 0, 85);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
